>>> design/mecr_pkg.sv
// ----------------------------------------------------------------------------
// mecr_pkg
// Types and constants shared by the MIDI event capture ring modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mecr_pkg;

   localparam int CAPACITY_DEF = 64;

   // status byte high nibbles
   localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
   localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
   localparam logic [3:0] NIB_CONTROL  = 4'hb;
   localparam logic [3:0] NIB_BEND     = 4'he;

   // event kinds
   localparam logic [2:0] KIND_NOTE_OFF = 3'd0;
   localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
   localparam logic [2:0] KIND_CONTROL  = 3'd2;
   localparam logic [2:0] KIND_BEND     = 3'd3;
   localparam logic [2:0] KIND_OTHER    = 3'd4;

   // request codes
   localparam logic REQ_PUSH  = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [7:0] status_byte;
      logic [7:0] first_data;
      logic [7:0] second_data;
      logic [1:0] msg_len;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [3:0]  channel;
      logic [6:0]  data_one;
      logic [6:0]  data_two;
      logic        last;
      logic [31:0] total_seen;
   } rsp_item_type;

   typedef struct packed {
      logic [2:0] event_kind;
      logic [3:0] channel;
      logic [6:0] data_one;
      logic [6:0] data_two;
   } event_entry_type;

   // controller to datapath
   typedef struct packed {
      logic push;
      logic load_drain;
      logic issue_read;
   } mecr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic drain_nonempty;
      logic final_read;
   } mecr_status_type;

endpackage

`default_nettype wire

>>> design/mecr_ctrl.sv
// ----------------------------------------------------------------------------
// mecr_ctrl
// Controller: takes requests and sequences the drain reads.
// ----------------------------------------------------------------------------
`default_nettype none

module mecr_ctrl
   import mecr_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic            req_kind,
   input  wire mecr_status_type status,
   output mecr_cmd_type         cmd,
   output logic                 busy
);

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      accept;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   always_comb begin
      cmd.push       = accept && (req_kind == REQ_PUSH);
      cmd.load_drain = accept && (req_kind == REQ_DRAIN);
      cmd.issue_read = (state_ff == ST_DRAIN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.load_drain && status.drain_nonempty) begin
                  state_ff <= ST_DRAIN;
                  busy_ff  <= 1'b1;
               end
            end
            ST_DRAIN: begin
               if (status.final_read) begin
                  state_ff <= ST_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> design/mecr_datapath.sv
// ----------------------------------------------------------------------------
// mecr_datapath
// Classifier, event ring memory, write and read counters, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mecr_datapath
   import mecr_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
)(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire req_item_type req_data,
   input  wire mecr_cmd_type cmd,
   output mecr_status_type   status,
   output logic              rsp_strobe,
   output rsp_item_type      rsp_data
);

   localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam longint unsigned WRAP_MOD = (64'd1 << 32) % CAPACITY;

   event_entry_type  event_store_ff [CAPACITY];
   event_entry_type  new_entry;
   event_entry_type  rd_entry_ff;

   logic [31:0]       wcount_ff;
   logic [SLOT_W-1:0] wslot_ff;
   logic [31:0]       rcount_ff;
   logic [SLOT_W-1:0] rslot_ff;

   logic [31:0]       pos_count_ff, pos_count_in;
   logic [SLOT_W-1:0] pos_slot_ff, pos_slot_in;
   logic [CNT_W-1:0]  remain_ff, remain_in;

   logic              rsp_valid_ff;
   logic              rsp_last_ff;

   logic [31:0]       gap;
   logic              behind;
   logic [SLOT_W:0]   wrap_sum;
   logic [SLOT_W-1:0] behind_slot;

   // slot follows count mod capacity, including the 32-bit wrap
   function automatic logic [SLOT_W-1:0] next_slot(input logic [31:0] count,
                                                   input logic [SLOT_W-1:0] slot);
      logic [SLOT_W-1:0] result;
      if (count == 32'hffff_ffff) begin
         result = '0;
      end else if (slot == SLOT_W'(CAPACITY - 1)) begin
         result = '0;
      end else begin
         result = slot + SLOT_W'(1);
      end
      return result;
   endfunction

   // classifier
   always_comb begin
      new_entry.channel  = req_data.status_byte[3:0];
      new_entry.data_one = req_data.first_data[6:0];
      new_entry.data_two = (req_data.msg_len == 2'd3) ? req_data.second_data[6:0] : 7'd0;
      unique case (req_data.status_byte[7:4])
         NIB_NOTE_OFF: new_entry.event_kind = KIND_NOTE_OFF;
         NIB_NOTE_ON:  new_entry.event_kind = (new_entry.data_two == 7'd0) ?
                                              KIND_NOTE_OFF : KIND_NOTE_ON;
         NIB_CONTROL:  new_entry.event_kind = KIND_CONTROL;
         NIB_BEND:     new_entry.event_kind = KIND_BEND;
         default:      new_entry.event_kind = KIND_OTHER;
      endcase
      if (req_data.msg_len < 2'd2) begin
         new_entry = '{event_kind: KIND_OTHER, channel: 4'd0, data_one: 7'd0,
                       data_two: 7'd0};
      end
   end

   // drain start: skip ahead when more than a ring behind
   always_comb begin
      gap      = wcount_ff - rcount_ff;
      behind   = gap > 32'(CAPACITY);
      // (write_count - CAPACITY) mod CAPACITY when that subtraction wraps
      wrap_sum = (SLOT_W + 1)'(WRAP_MOD) + {1'b0, wslot_ff};
      if (wcount_ff >= 32'(CAPACITY)) begin
         behind_slot = wslot_ff;
      end else if (wrap_sum >= (SLOT_W + 1)'(CAPACITY)) begin
         behind_slot = SLOT_W'(wrap_sum - (SLOT_W + 1)'(CAPACITY));
      end else begin
         behind_slot = wrap_sum[SLOT_W-1:0];
      end
      status.drain_nonempty = (gap != 32'd0);
      status.final_read     = (remain_ff == CNT_W'(1));
   end

   always_comb begin
      priority if (cmd.load_drain) begin
         pos_count_in = behind ? (wcount_ff - 32'(CAPACITY)) : rcount_ff;
         pos_slot_in  = behind ? behind_slot : rslot_ff;
         remain_in    = behind ? CNT_W'(CAPACITY) : gap[CNT_W-1:0];
      end else if (cmd.issue_read) begin
         pos_count_in = pos_count_ff + 32'd1;
         pos_slot_in  = next_slot(pos_count_ff, pos_slot_ff);
         remain_in    = remain_ff - CNT_W'(1);
      end else begin
         pos_count_in = pos_count_ff;
         pos_slot_in  = pos_slot_ff;
         remain_in    = remain_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         event_store_ff[wslot_ff] <= new_entry;
      end
      if (cmd.issue_read) begin
         rd_entry_ff <= event_store_ff[pos_slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      pos_count_ff <= pos_count_in;
      pos_slot_ff  <= pos_slot_in;
      rsp_last_ff  <= cmd.issue_read && status.final_read;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wcount_ff    <= '0;
         wslot_ff     <= '0;
         rcount_ff    <= '0;
         rslot_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         remain_ff    <= remain_in;
         rsp_valid_ff <= cmd.issue_read;
         if (cmd.push) begin
            wcount_ff <= wcount_ff + 32'd1;
            wslot_ff  <= next_slot(wcount_ff, wslot_ff);
         end
         if (cmd.load_drain) begin
            rcount_ff <= wcount_ff;
            rslot_ff  <= wslot_ff;
         end
      end
   end

   assign rsp_strobe = rsp_valid_ff;

   always_comb begin
      rsp_data.event_kind = rd_entry_ff.event_kind;
      rsp_data.channel    = rd_entry_ff.channel;
      rsp_data.data_one   = rd_entry_ff.data_one;
      rsp_data.data_two   = rd_entry_ff.data_two;
      rsp_data.last       = rsp_last_ff;
      rsp_data.total_seen = wcount_ff;
   end

endmodule

`default_nettype wire

>>> design/midi_event_capture_ring_unit.sv
// ----------------------------------------------------------------------------
// midi_event_capture_ring_unit
// MIDI message classifier feeding an overwrite ring, drained on request.
// ----------------------------------------------------------------------------
//  channel   ports                     transfer
//  request   start, busy, req_data     start high while busy low
//  result    rsp_strobe, rsp_data      every cycle rsp_strobe is high
//
//  a push leaves busy low, so pushes may follow every cycle. a drain holds
//  busy high while it reads the n waiting events (the newest CAPACITY if
//  more wait), one ring read per cycle; each result comes in the cycle after
//  its read, n results in total. a drain with nothing waiting gives no result.
//  reset clears the counters; ring entries need no clearing.
//  the receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_event_capture_ring_unit
   import mecr_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
)(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   start,
   output logic        busy,
   input  wire req_item_type req_data,
   output logic        rsp_strobe,
   output rsp_item_type rsp_data
);

   mecr_cmd_type    cmd;
   mecr_status_type status;

   mecr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_data.req_type),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   mecr_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
